// File: sv/rop_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rop_pkg: shared types for the rectangle outline pixel generator
// Action and corner mode codes used by the channels and the scan logic.
// ----------------------------------------------------------------------------
package rop_pkg;

	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

	typedef enum logic {
		CORNER_SQUARE = 1'b0,
		CORNER_ROUND  = 1'b1
	} corner_mode_t;

endpackage
`default_nettype wire

// File: sv/rop_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rop_in_if: input item channel
// Valid/ready channel that carries start and advance items.
// ----------------------------------------------------------------------------
interface rop_in_if #(
	parameter int COORD_BITS = 12,
	parameter int COLOR_BITS = 32
);
	logic                    valid;
	logic                    ready;
	rop_pkg::action_t        action;
	logic [COORD_BITS-1:0]   origin_x;
	logic [COORD_BITS-1:0]   origin_y;
	logic [COORD_BITS-1:0]   rect_width;
	logic [COORD_BITS-1:0]   rect_height;
	logic [COORD_BITS-1:0]   border_thickness;
	logic [COLOR_BITS-1:0]   fill_color;
	rop_pkg::corner_mode_t   corner_mode;

	modport source (
		output valid, action, origin_x, origin_y, rect_width, rect_height,
		       border_thickness, fill_color, corner_mode,
		input  ready
	);
	modport sink (
		input  valid, action, origin_x, origin_y, rect_width, rect_height,
		       border_thickness, fill_color, corner_mode,
		output ready
	);
endinterface
`default_nettype wire

// File: sv/rop_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rop_out_if: result item channel
// Valid/ready channel that carries one pixel result per transaction.
// ----------------------------------------------------------------------------
interface rop_out_if #(
	parameter int COORD_BITS = 12,
	parameter int COLOR_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic                  write_enable;
	logic [COORD_BITS:0]   pixel_x;
	logic [COORD_BITS:0]   pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  scan_done;

	modport source (
		output valid, write_enable, pixel_x, pixel_y, pixel_color, scan_done,
		input  ready
	);
	modport sink (
		input  valid, write_enable, pixel_x, pixel_y, pixel_color, scan_done,
		output ready
	);
endinterface
`default_nettype wire

// File: sv/rect_outline_pixel_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rect_outline_pixel_generator: rectangle outline raster scan
// Turn start/advance items into per-position pixel writes for an outline.
// ----------------------------------------------------------------------------
// An advance item's result is offered from the result register: the input register
// loads at the accepting edge and the result register when the pipe next advances.
// Throughput: one item per cycle; both stages advance together whenever the
// result register is empty or its transaction completes.
// Reset: no item held, rectangle registers cleared, scan marked finished so an
// advance before any start gives an empty result with scan_done set.
module rect_outline_pixel_generator #(
	parameter int COORD_BITS = 12,
	parameter int COLOR_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	rop_in_if.sink   in_ch,
	rop_out_if.source out_ch
);
	// stage 1: accepted item
	logic                  valid_s1;
	rop_pkg::action_t      action_s1;
	logic [COORD_BITS-1:0] origin_x_s1, origin_y_s1, width_s1, height_s1, thick_s1;
	logic [COLOR_BITS-1:0] color_s1;
	rop_pkg::corner_mode_t mode_s1;

	// stage 2: result register
	logic                  valid_s2;
	logic                  we_s2;
	logic [COORD_BITS:0]   pix_x_s2, pix_y_s2;
	logic [COLOR_BITS-1:0] color_s2;
	logic                  done_s2;

	// scan state seen by stage 1
	logic [COORD_BITS-1:0] col, row, size_w, size_h, band;
	rop_pkg::corner_mode_t rounded;
	logic [COORD_BITS:0]   pix_x, pix_y;
	logic [COLOR_BITS-1:0] color;
	logic                  finished, last, write_enable;
	logic                  advance;

	// Advance the whole pipe when the result register is free or being drained.
	assign advance     = !valid_s2 || out_ch.ready;
	assign in_ch.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Payload of stage 1 needs no reset; load on every advance.
	always_ff @(posedge clk) begin
		if (advance) begin
			action_s1   <= in_ch.action;
			origin_x_s1 <= in_ch.origin_x;
			origin_y_s1 <= in_ch.origin_y;
			width_s1    <= in_ch.rect_width;
			height_s1   <= in_ch.rect_height;
			thick_s1    <= in_ch.border_thickness;
			color_s1    <= in_ch.fill_color;
			mode_s1     <= in_ch.corner_mode;
		end
	end

	// Scan state updates as the stage-1 item moves on.
	rop_scan #(
		.COORD_BITS(COORD_BITS),
		.COLOR_BITS(COLOR_BITS)
	) u_scan (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (valid_s1 && advance),
		.action           (action_s1),
		.origin_x         (origin_x_s1),
		.origin_y         (origin_y_s1),
		.rect_width       (width_s1),
		.rect_height      (height_s1),
		.border_thickness (thick_s1),
		.fill_color       (color_s1),
		.corner_mode      (mode_s1),
		.col              (col),
		.row              (row),
		.size_w           (size_w),
		.size_h           (size_h),
		.band             (band),
		.rounded          (rounded),
		.pix_x            (pix_x),
		.pix_y            (pix_y),
		.color            (color),
		.finished         (finished),
		.last             (last)
	);

	rop_flag #(
		.COORD_BITS(COORD_BITS)
	) u_flag (
		.col          (col),
		.row          (row),
		.size_w       (size_w),
		.size_h       (size_h),
		.band         (band),
		.corner_mode  (rounded),
		.write_enable (write_enable)
	);

	// Only advance items produce a result; a start item just drops out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && (action_s1 == rop_pkg::ACT_ADVANCE);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (finished) begin
				// nothing left to scan: empty result that flags the end
				we_s2    <= 1'b0;
				pix_x_s2 <= '0;
				pix_y_s2 <= '0;
				color_s2 <= '0;
				done_s2  <= 1'b1;
			end else begin
				we_s2    <= write_enable;
				pix_x_s2 <= pix_x;
				pix_y_s2 <= pix_y;
				color_s2 <= color;
				done_s2  <= last;
			end
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.write_enable = we_s2;
	assign out_ch.pixel_x      = pix_x_s2;
	assign out_ch.pixel_y      = pix_y_s2;
	assign out_ch.pixel_color  = color_s2;
	assign out_ch.scan_done    = done_s2;

`ifndef SYNTH
	a_start_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && (action_s1 == rop_pkg::ACT_START) |=> !out_ch.valid)
		else $error("start transaction produced a result");
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && (action_s1 == rop_pkg::ACT_ADVANCE) && finished
		|=> out_ch.valid && out_ch.scan_done && !out_ch.write_enable &&
		    (out_ch.pixel_x == '0) && (out_ch.pixel_y == '0) && (out_ch.pixel_color == '0))
		else $error("empty end-of-scan result carries payload");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pixel_x))
		else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// File: sv/rop_flag.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rop_flag: outline membership test
// Decide whether a rectangle position lies on the square or rounded outline.
// ----------------------------------------------------------------------------
module rop_flag #(
	parameter int COORD_BITS = 12
) (
	input  wire logic [COORD_BITS-1:0] col,
	input  wire logic [COORD_BITS-1:0] row,
	input  wire logic [COORD_BITS-1:0] size_w,
	input  wire logic [COORD_BITS-1:0] size_h,
	input  wire logic [COORD_BITS-1:0] band,
	input  wire rop_pkg::corner_mode_t corner_mode,
	output logic                       write_enable
);
	// two extra bits: one for 2t, one as sign of a bound that went negative
	localparam int D = COORD_BITS + 2;

	logic [D-1:0] c_e, r_e, w_e, h_e, t_e, t2_e;
	logic [D-1:0] bw1, bw2, bh1, bh2;
	logic         in_band, cx, cy, corner_sq;

	// x >= bound, false on a negative bound
	function automatic logic ge_bound(input logic [D-1:0] x, input logic [D-1:0] b);
		return !b[D-1] && (x >= b);
	endfunction

	// bound > x, true on a negative bound
	function automatic logic gt_bound(input logic [D-1:0] b, input logic [D-1:0] x);
		return b[D-1] || (b > x);
	endfunction

	always_comb begin
		c_e  = {2'b00, col};
		r_e  = {2'b00, row};
		w_e  = {2'b00, size_w};
		h_e  = {2'b00, size_h};
		t_e  = {2'b00, band};
		t2_e = {1'b0, band, 1'b0};
		bw1  = w_e - t_e;
		bw2  = w_e - t2_e;
		bh1  = h_e - t_e;
		bh2  = h_e - t2_e;

		in_band = (c_e < t_e) || ge_bound(c_e, bw1) ||
		          (r_e < t_e) || ge_bound(r_e, bh1);
		cx = ((t_e <= c_e) && (c_e < t2_e)) || (gt_bound(bw1, c_e) && ge_bound(c_e, bw2));
		cy = ((t_e <= r_e) && (r_e < t2_e)) || (gt_bound(bh1, r_e) && ge_bound(r_e, bh2));
		corner_sq = ((c_e < t2_e) || ge_bound(c_e, bw2)) &&
		            ((r_e < t2_e) || ge_bound(r_e, bh2));

		if (corner_mode == rop_pkg::CORNER_ROUND) begin
			write_enable = (cx && cy) || (in_band && !corner_sq);
		end else begin
			write_enable = in_band;
		end
	end
endmodule
`default_nettype wire

// File: sv/rop_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rop_scan: rectangle registers and raster counters
// Load a rectangle on a start item and step row-major on each advance item.
// ----------------------------------------------------------------------------
module rop_scan #(
	parameter int COORD_BITS = 12,
	parameter int COLOR_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire rop_pkg::action_t      action,
	input  wire logic [COORD_BITS-1:0] origin_x,
	input  wire logic [COORD_BITS-1:0] origin_y,
	input  wire logic [COORD_BITS-1:0] rect_width,
	input  wire logic [COORD_BITS-1:0] rect_height,
	input  wire logic [COORD_BITS-1:0] border_thickness,
	input  wire logic [COLOR_BITS-1:0] fill_color,
	input  wire rop_pkg::corner_mode_t corner_mode,
	output logic [COORD_BITS-1:0]      col,
	output logic [COORD_BITS-1:0]      row,
	output logic [COORD_BITS-1:0]      size_w,
	output logic [COORD_BITS-1:0]      size_h,
	output logic [COORD_BITS-1:0]      band,
	output rop_pkg::corner_mode_t      rounded,
	output logic [COORD_BITS:0]        pix_x,
	output logic [COORD_BITS:0]        pix_y,
	output logic [COLOR_BITS-1:0]      color,
	output logic                       finished,
	output logic                       last
);
	logic [COORD_BITS-1:0] base_x_q, base_y_q, size_w_q, size_h_q, band_q;
	logic [COORD_BITS-1:0] col_q, row_q;
	logic [COLOR_BITS-1:0] color_q;
	rop_pkg::corner_mode_t rounded_q;
	logic                  finished_q;
	logic [COORD_BITS:0]   col_inc, row_inc;
	logic                  col_wrap, row_wrap;

	always_comb begin
		col_inc  = {1'b0, col_q} + {{COORD_BITS{1'b0}}, 1'b1};
		row_inc  = {1'b0, row_q} + {{COORD_BITS{1'b0}}, 1'b1};
		col_wrap = col_inc >= {1'b0, size_w_q};
		row_wrap = row_inc >= {1'b0, size_h_q};
		last     = !finished_q && col_wrap && row_wrap;
		pix_x    = {1'b0, base_x_q} + {1'b0, col_q};
		pix_y    = {1'b0, base_y_q} + {1'b0, row_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q   <= '0;
			base_y_q   <= '0;
			size_w_q   <= '0;
			size_h_q   <= '0;
			band_q     <= '0;
			color_q    <= '0;
			rounded_q  <= rop_pkg::CORNER_SQUARE;
			col_q      <= '0;
			row_q      <= '0;
			finished_q <= 1'b1;
		end else if (step) begin
			if (action == rop_pkg::ACT_START) begin
				base_x_q   <= origin_x;
				base_y_q   <= origin_y;
				size_w_q   <= rect_width;
				size_h_q   <= rect_height;
				band_q     <= border_thickness;
				color_q    <= fill_color;
				rounded_q  <= corner_mode;
				col_q      <= '0;
				row_q      <= '0;
				finished_q <= (rect_width == '0) || (rect_height == '0);
			end else if (!finished_q) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[COORD_BITS-1:0];
				end else begin
					col_q <= col_inc[COORD_BITS-1:0];
				end
				if (last) begin
					finished_q <= 1'b1;
				end
			end
		end
	end

	assign col      = col_q;
	assign row      = row_q;
	assign size_w   = size_w_q;
	assign size_h   = size_h_q;
	assign band     = band_q;
	assign rounded  = rounded_q;
	assign color    = color_q;
	assign finished = finished_q;

`ifndef SYNTH
	a_idle_rewound: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> (col_q == '0) && (row_q == '0))
		else $error("scan idle with counters away from origin");
	a_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!finished_q |-> (col_q < size_w_q) && (row_q < size_h_q))
		else $error("scan position outside rectangle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && (action == rop_pkg::ACT_ADVANCE) && last |=> finished_q)
		else $error("final position did not end the scan");
`endif
endmodule
`default_nettype wire
